@@ src/fqste_pkg.sv @@
package fqste_pkg;

   // register indexes
   localparam logic [2:0] CSR_SCALE      = 3'd0;
   localparam logic [2:0] CSR_RECIP      = 3'd1;
   localparam logic [2:0] CSR_ZERO       = 3'd2;
   localparam logic [2:0] CSR_RANGE_LOW  = 3'd3;
   localparam logic [2:0] CSR_RANGE_HIGH = 3'd4;

   localparam logic [31:0]       ONE_F32        = 32'h3F80_0000;
   localparam logic signed [8:0] RANGE_LOW_RST  = -9'sd128;
   localparam logic signed [8:0] RANGE_HIGH_RST = 9'sd127;

   localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
   localparam logic [31:0] NEG_ZERO    = 32'h8000_0000;

   localparam int NUM_STAGES = 9;

   // multiplier front half: special result or raw significand product
   typedef struct packed {
      logic               special;
      logic [31:0]        special_bits;
      logic               sign;
      logic signed [10:0] expo;
      logic [47:0]        prod;
   } mul_mid_type;

   typedef struct packed {
      logic               mode;
      logic [31:0]        x;
      logic [31:0]        grad;
      logic [31:0]        op_a;
      logic [31:0]        op_b;
      mul_mid_type        mid;
      logic [31:0]        f1;
      logic [31:0]        lo;
      logic [50:0]        s_mag;
      logic               s_neg;
      logic               s_sat;
      logic               nan;
      logic signed [11:0] q;
      logic               q_negz;
      logic [31:0]        result;
   } pl_type;

   function automatic logic is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   // exact for the small integers used here
   function automatic logic [31:0] int_to_float(input logic signed [11:0] v);
      logic [10:0] m;
      logic [3:0]  lead;
      logic [23:0] tmp;
      m = v[11] ? 11'(-v) : v[10:0];
      lead = 4'd0;
      for (int i = 0; i < 11; i++) begin
         if (m[i]) lead = 4'(i);
      end
      tmp = {13'd0, m} << (5'd23 - {1'b0, lead});
      if (m == 11'd0) return 32'd0;
      return {v[11], 8'd127 + {4'd0, lead}, tmp[22:0]};
   endfunction

   function automatic mul_mid_type mul_front(input logic [31:0] a, input logic [31:0] b);
      mul_mid_type r;
      logic [7:0]  ea, eb;
      logic        a_inf, b_inf, a_zero, b_zero;
      ea = a[30:23];
      eb = b[30:23];
      a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = a[30:0] == 31'd0;
      b_zero = b[30:0] == 31'd0;
      r.sign = a[31] ^ b[31];
      r.special = 1'b1;
      r.special_bits = {r.sign, 31'd0};
      if (is_nan(a)) r.special_bits = a | QUIET_BIT;
      else if (is_nan(b)) r.special_bits = b | QUIET_BIT;
      else if ((a_inf && b_zero) || (a_zero && b_inf)) r.special_bits = DEFAULT_NAN;
      else if (a_inf || b_inf) r.special_bits = {r.sign, 8'hFF, 23'd0};
      else if (a_zero || b_zero) r.special_bits = {r.sign, 31'd0};
      else r.special = 1'b0;
      r.expo = $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea})
             + $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd127;
      r.prod = {ea != 8'd0, a[22:0]} * {eb != 8'd0, b[22:0]};
      return r;
   endfunction

   // normalize and round to nearest even, subnormals included
   function automatic logic [31:0] mul_back(input mul_mid_type m);
      logic [5:0]         lead, sh, rs;
      logic [47:0]        nrm;
      logic signed [10:0] e;
      logic [71:0]        ext;
      logic [23:0]        sig;
      logic               guard, sticky, up;
      logic [7:0]         ef;
      logic [30:0]        mag;
      lead = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (m.prod[i]) lead = 6'(i);
      end
      sh  = 6'd47 - lead;
      nrm = m.prod << sh;
      e   = m.expo - $signed({5'd0, sh}) + 11'sd1;
      if (e <= 11'sd0) begin
         rs = (e < -11'sd46) ? 6'd48 : 6'(11'sd1 - e);
         ef = 8'd0;
      end else begin
         rs = 6'd0;
         ef = e[7:0];
      end
      ext    = {nrm, 24'd0} >> rs;
      sig    = ext[71:48];
      guard  = ext[47];
      sticky = |ext[46:0];
      up     = guard & (sticky | sig[0]);
      mag    = {ef, sig[22:0]} + {30'd0, up};
      if (m.special) return m.special_bits;
      if (e >= 11'sd255) return {m.sign, 8'hFF, 23'd0};
      return {m.sign, mag};
   endfunction

   function automatic logic fp_le(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ka, kb;
      logic        bothz;
      ka = a[31] ? ~a : (a | NEG_ZERO);
      kb = b[31] ? ~b : (b | NEG_ZERO);
      bothz = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      return !is_nan(a) && !is_nan(b) && (bothz || (ka <= kb));
   endfunction

endpackage

@@ src/fake_quantize_ste.sv @@
// Per-tensor affine fake quantizer on float32. A request with mode 0 returns
// (clamp(round(x*recip + zp), qmin, qmax) - zp) * scale, rounding halves away
// from zero; mode 1 returns grad when (qmin-zp)*scale <= x <= (qmax-zp)*scale
// and +0.0 otherwise (NaN x gives +0.0). Each request yields one response,
// in order; a new request can be taken every cycle unless a full pipeline is
// held by rsp_ready low. The block is a nine-stage pipeline: two float multipliers,
// each split into a product stage and a normalize/round stage, plus operand
// setup, the zero-point add, rounding and clamping, integer subtract and the
// final range compare. The registers are used as written (recip is not
// checked against scale) and should be changed only while the block is
// empty. Writes to indexes above four are ignored.
module fake_quantize_ste (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_x_value,
   input  logic [31:0] req_grad_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_value,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int NS = fqste_pkg::NUM_STAGES;

   logic [31:0]       scale_ff, recip_ff;
   logic signed [8:0] zp_ff, qmin_ff, qmax_ff;

   logic [NS-1:0]      vld_ff;
   logic [NS:0]        en;
   fqste_pkg::pl_type  pl_ff  [NS];
   fqste_pkg::pl_type  pl_in  [NS];

   // -------------------------------------------------------------------------
   // configuration registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= fqste_pkg::ONE_F32;
         recip_ff <= fqste_pkg::ONE_F32;
         zp_ff    <= 9'sd0;
         qmin_ff  <= fqste_pkg::RANGE_LOW_RST;
         qmax_ff  <= fqste_pkg::RANGE_HIGH_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            fqste_pkg::CSR_SCALE:      scale_ff <= csr_data;
            fqste_pkg::CSR_RECIP:      recip_ff <= csr_data;
            fqste_pkg::CSR_ZERO:       zp_ff    <= $signed(csr_data[8:0]);
            fqste_pkg::CSR_RANGE_LOW:  qmin_ff  <= $signed(csr_data[8:0]);
            fqste_pkg::CSR_RANGE_HIGH: qmax_ff  <= $signed(csr_data[8:0]);
            default: ;
         endcase
      end
   end

   logic signed [11:0] zp12, qmin12, qmax12;
   logic [8:0]         zmag;
   assign zp12   = 12'(zp_ff);
   assign qmin12 = 12'(qmin_ff);
   assign qmax12 = 12'(qmax_ff);
   assign zmag   = zp_ff[8] ? 9'(-zp12) : {1'b0, zp_ff[7:0]};

   // -------------------------------------------------------------------------
   // exact s = fl(p + zp), kept as |s| with 26 fraction bits (floored) and sign
   // -------------------------------------------------------------------------
   function automatic fqste_pkg::pl_type do_sum(input fqste_pkg::pl_type p);
      fqste_pkg::pl_type r;
      logic [7:0]  ex, eu;
      logic [23:0] sig;
      logic [49:0] pfix;
      logic [55:0] tmp;
      logic [5:0]  rs;
      logic        stk, sp, sz, zz;
      logic [50:0] z, pf;
      r   = p;
      ex  = p.f1[30:23];
      eu  = (ex == 8'd0) ? 8'd1 : ex;
      sig = {ex != 8'd0, p.f1[22:0]};
      sp  = p.f1[31];
      sz  = zp_ff[8];
      zz  = zp_ff == 9'sd0;
      rs  = (eu < 8'd92) ? 6'd32 : 6'(8'd124 - eu);
      tmp = {sig, 32'd0} >> rs;
      if (eu >= 8'd124) begin
         pfix = {26'd0, sig} << 5'(eu - 8'd124);
         stk  = 1'b0;
      end else begin
         pfix = {26'd0, tmp[55:32]};
         stk  = |tmp[31:0];
      end
      z  = {16'd0, zmag, 26'd0};
      pf = {1'b0, pfix};
      r.lo    = p.f1;
      r.nan   = fqste_pkg::is_nan(p.f1);
      r.s_sat = ex >= 8'd151;
      if (zz || (sp == sz)) begin
         r.s_mag = z + pf;
         r.s_neg = zz ? (sp && ((pf != 51'd0) || stk)) : sz;
      end else if ((pf > z) || ((pf == z) && stk)) begin
         r.s_mag = pf - z;
         r.s_neg = sp;
      end else begin
         r.s_mag = z - pf - {50'd0, stk};
         r.s_neg = sz && !((pf == z) && !stk);   // exact cancel gives +0
      end
      if (r.s_sat) r.s_neg = sp;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // round half away from zero, then lower clamp, then upper clamp (clamps skipped for NaN)
   // -------------------------------------------------------------------------
   function automatic fqste_pkg::pl_type do_round(input fqste_pkg::pl_type p);
      fqste_pkg::pl_type  r;
      logic [9:0]         n;
      logic [25:0]        frac, thr;
      logic [3:0]         k;
      logic [10:0]        rmag;
      logic signed [11:0] q;
      logic               negz;
      r    = p;
      n    = p.s_mag[35:26];
      frac = p.s_mag[25:0];
      k    = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (n[i]) k = 4'(i);
      end
      // a float just under n+0.5 can round up to it; the margin is half its ulp
      thr  = (n == 10'd0) ? 26'h1FF_FFFF : (26'h200_0000 - (26'd4 << k));
      if (p.s_sat || (p.s_mag[50:36] != 15'd0)) rmag = 11'd1023;
      else rmag = {1'b0, n} + {10'd0, frac >= thr};
      q    = p.s_neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
      negz = p.s_neg && (rmag == 11'd0);
      if (!p.nan) begin
         if (q < qmin12) begin
            q    = qmin12;
            negz = 1'b0;
         end
         if (q > qmax12) begin
            q    = qmax12;
            negz = 1'b0;
         end
      end
      r.q      = q;
      r.q_negz = negz;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // stage logic
   // -------------------------------------------------------------------------
   always_comb begin
      pl_in[0]      = '0;
      pl_in[0].mode = req_mode;
      pl_in[0].x    = req_x_value;
      pl_in[0].grad = req_grad_value;
      pl_in[0].op_a = req_mode ? fqste_pkg::int_to_float(qmin12 - zp12) : req_x_value;
      pl_in[0].op_b = req_mode ? scale_ff : recip_ff;

      pl_in[1]     = pl_ff[0];
      pl_in[1].mid = fqste_pkg::mul_front(pl_ff[0].op_a, pl_ff[0].op_b);

      pl_in[2]    = pl_ff[1];
      pl_in[2].f1 = fqste_pkg::mul_back(pl_ff[1].mid);   // x*recip, or lower bound

      pl_in[3] = do_sum(pl_ff[2]);
      pl_in[4] = do_round(pl_ff[3]);

      // q - zp is exact; a NaN rides through as the first multiplier operand
      pl_in[5]      = pl_ff[4];
      pl_in[5].op_b = scale_ff;
      if (pl_ff[4].mode)
         pl_in[5].op_a = fqste_pkg::int_to_float(qmax12 - zp12);
      else if (pl_ff[4].nan)
         pl_in[5].op_a = pl_ff[4].f1;
      else if (pl_ff[4].q_negz && (zp_ff == 9'sd0))
         pl_in[5].op_a = fqste_pkg::NEG_ZERO;
      else
         pl_in[5].op_a = fqste_pkg::int_to_float(pl_ff[4].q - zp12);

      pl_in[6]     = pl_ff[5];
      pl_in[6].mid = fqste_pkg::mul_front(pl_ff[5].op_a, pl_ff[5].op_b);

      pl_in[7]        = pl_ff[6];
      pl_in[7].result = fqste_pkg::mul_back(pl_ff[6].mid);   // dequantized, or upper bound

      pl_in[8] = pl_ff[7];
      if (pl_ff[7].mode) begin
         pl_in[8].result = (fqste_pkg::fp_le(pl_ff[7].lo, pl_ff[7].x) &&
                            fqste_pkg::fp_le(pl_ff[7].x, pl_ff[7].result)) ?
                           pl_ff[7].grad : 32'd0;
      end
   end

   // -------------------------------------------------------------------------
   // pipeline advance: a stage loads when it is empty or its successor moves
   // -------------------------------------------------------------------------
   always_comb begin
      en[NS] = rsp_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) pl_ff[k] <= pl_in[k];
      end
   end

   assign req_ready        = en[0];
   assign rsp_valid        = vld_ff[NS-1];
   assign rsp_result_value = pl_ff[NS-1].result;

   // -------------------------------------------------------------------------
   // assertions
   // -------------------------------------------------------------------------
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_ready) |-> !req_ready)
      else $error("full stalled pipeline still accepts");

   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && !pl_ff[4].mode && !pl_ff[4].nan && (qmin_ff <= qmax_ff))
      |-> ((pl_ff[4].q >= qmin12) && (pl_ff[4].q <= qmax12)))
      else $error("quantized level outside range");

   a_mask_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && pl_ff[NS-1].mode)
      |-> ((rsp_result_value == 32'd0) || (rsp_result_value == pl_ff[NS-1].grad)))
      else $error("backward response is neither gradient nor zero");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

   // float constants used by the stimulus
   localparam logic [31:0] F32_QNAN    = 32'h7FC0_0000;
   localparam logic [31:0] F32_POS_INF = 32'h7F80_0000;
   localparam logic [31:0] F32_NEG_INF = 32'hFF80_0000;
   localparam logic [31:0] F32_HALF    = 32'h3F00_0000;
   localparam logic [31:0] F32_TENTH   = 32'h3DCC_CCCD;
   localparam logic [31:0] F32_TEN     = 32'h4120_0000;
   localparam logic [31:0] F32_TWENTY  = 32'h41A0_0000;
   localparam logic [31:0] F32_FIVE_PC = 32'h3D4C_CCCD;
   localparam logic        MODE_FWD    = 1'b0;
   localparam logic        MODE_BWD    = 1'b1;
   localparam logic [2:0]  CSR_SPARE_5 = 3'd5;
   localparam logic [2:0]  CSR_SPARE_7 = 3'd7;
   localparam int          MAX_REPORTS = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [31:0] req_x_value;
   logic [31:0] req_grad_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_result_value;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   fake_quantize_ste DUT (.*);

   // shadow copy of the register file
   logic [31:0]       cfg_scale;
   logic [31:0]       cfg_recip;
   logic signed [8:0] cfg_zero;
   logic signed [8:0] cfg_qmin;
   logic signed [8:0] cfg_qmax;

   logic [31:0] pending_results[$];
   int          mismatch_count;
   logic        quiet_phase;   // when set neither side idles

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------- float32 arithmetic, round to nearest even ----------------
   function automatic logic f_nan(input logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 0;
   endfunction

   function automatic logic f_inf(input logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] == 0;
   endfunction

   function automatic logic f_zero(input logic [31:0] a);
      return a[30:0] == 0;
   endfunction

   function automatic logic [63:0] f_mant(input logic [31:0] a);
      return (a[30:23] == 0) ? {41'd0, a[22:0]} : {40'd0, 1'b1, a[22:0]};
   endfunction

   function automatic int f_expo(input logic [31:0] a);
      return (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
   endfunction

   // value is sgn * m * 2^e, exact; round it once into float32
   function automatic logic [31:0] f_pack(input logic sgn, input int e, input logic [63:0] m);
      int           p, lsb, sh, be;
      logic [127:0] w, r, rem, half;
      p = 0;
      for (int i = 0; i < 64; i++) if (m[i]) p = i;
      lsb = p + e - 23;
      if (lsb < -149) lsb = -149;
      sh = lsb - e;
      w = {64'd0, m};
      if (m == 0) return {sgn, 31'd0};
      if (sh > 0) begin
         if (sh > 100) sh = 100;
         r    = w >> sh;
         rem  = w - (r << sh);
         half = 128'd1 << (sh - 1);
         if (rem > half || (rem == half && r[0])) r = r + 1;
      end else begin
         r = w << (-sh);
      end
      if (r == (128'd1 << 24)) begin
         r = r >> 1;
         lsb++;
      end
      if (r == 0) return {sgn, 31'd0};
      if (r < (128'd1 << 23)) return {sgn, 8'd0, r[22:0]};
      be = lsb + 150;
      if (be >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, be[7:0], r[22:0]};
   endfunction

   function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
      logic sgn;
      sgn = a[31] ^ b[31];
      if (f_nan(a) || f_nan(b)) return F32_QNAN;
      if ((f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b))) return F32_QNAN;
      if (f_inf(a) || f_inf(b)) return {sgn, 8'hFF, 23'd0};
      if (f_zero(a) || f_zero(b)) return {sgn, 31'd0};
      return f_pack(sgn, f_expo(a) + f_expo(b), f_mant(a) * f_mant(b));
   endfunction

   function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] hi_op, lo_op;
      logic [63:0] big, sml, sum;
      logic        sgn;
      int          eb, d;
      if (f_nan(a) || f_nan(b)) return F32_QNAN;
      if (f_inf(a) && f_inf(b)) return (a[31] == b[31]) ? a : F32_QNAN;
      if (f_inf(a)) return a;
      if (f_inf(b)) return b;
      if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'd0};
      if (f_zero(a)) return b;
      if (f_zero(b)) return a;
      if (f_expo(a) >= f_expo(b)) begin
         hi_op = a;
         lo_op = b;
      end else begin
         hi_op = b;
         lo_op = a;
      end
      // widen the larger operand, fold the far tail of the smaller into a sticky bit
      big = f_mant(hi_op) << 38;
      eb  = f_expo(hi_op) - 38;
      d   = eb - f_expo(lo_op);
      if (d <= 0) sml = f_mant(lo_op) << (-d);
      else if (d >= 64) sml = 64'd1;
      else sml = (f_mant(lo_op) >> d) | ((f_mant(lo_op) & ((64'd1 << d) - 1)) != 0);
      if (hi_op[31] == lo_op[31]) begin
         sum = big + sml;
         sgn = hi_op[31];
      end else if (big >= sml) begin
         sum = big - sml;
         sgn = hi_op[31];
      end else begin
         sum = sml - big;
         sgn = lo_op[31];
      end
      if (sum == 0) return 32'd0;
      return f_pack(sgn, eb, sum);
   endfunction

   // nearest integer, ties away from zero; sign of zero kept
   function automatic logic [31:0] f_round_away(input logic [31:0] v);
      int          sh;
      logic [63:0] n;
      if (f_nan(v) || v[30:23] >= 8'd150) return v;
      sh = -f_expo(v);
      n  = (sh >= 63) ? 64'd0 : ((f_mant(v) + (64'd1 << (sh - 1))) >> sh);
      return f_pack(v[31], 0, n);
   endfunction

   function automatic longint f_key(input logic [31:0] a);
      return a[31] ? -longint'(a[30:0]) : longint'(a[30:0]);
   endfunction

   function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
      return !f_nan(a) && !f_nan(b) && f_key(a) < f_key(b);
   endfunction

   function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
      return !f_nan(a) && !f_nan(b) && f_key(a) <= f_key(b);
   endfunction

   function automatic logic [31:0] f_from_int(input int v);
      if (v == 0) return 32'd0;
      return f_pack(v < 0, 0, 64'(v < 0 ? -v : v));
   endfunction

   // ---------------- expected result of one request ----------------
   function automatic logic [31:0] fake_quant_predict(input logic mode, input logic [31:0] x,
                                                      input logic [31:0] grad);
      logic [31:0] zpf, nzp, qminf, qmaxf, q, lo_edge, hi_edge;
      zpf   = f_from_int(cfg_zero);
      nzp   = zpf ^ fqste_pkg::NEG_ZERO;
      qminf = f_from_int(cfg_qmin);
      qmaxf = f_from_int(cfg_qmax);
      if (mode == MODE_FWD) begin
         q = f_round_away(f_add(f_mul(x, cfg_recip), zpf));
         if (f_lt(q, qminf)) q = qminf;
         if (f_lt(qmaxf, q)) q = qmaxf;
         return f_mul(f_add(q, nzp), cfg_scale);
      end
      lo_edge = f_mul(f_add(qminf, nzp), cfg_scale);
      hi_edge = f_mul(f_add(qmaxf, nzp), cfg_scale);
      return (f_le(lo_edge, x) && f_le(x, hi_edge)) ? grad : 32'd0;
   endfunction

   // ---------------- response checker ----------------
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response %h", rsp_result_value);
         end else begin
            want = pending_results.pop_front();
            // any NaN matches a NaN, its payload is not pinned down
            if (!(want === rsp_result_value || (f_nan(want) && f_nan(rsp_result_value)))) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result mismatch: expected %h actual %h", want, rsp_result_value);
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b1;
      else rsp_ready <= quiet_phase || ($urandom_range(0, 99) >= 9);
   end

   // ---------------- driver tasks ----------------
   task automatic send_request(input logic mode, input logic [31:0] x, input logic [31:0] grad);
      if (!quiet_phase && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_x_value    <= x;
      req_grad_value <= grad;
      do @(posedge clock); while (!req_ready);
      pending_results = {pending_results, fake_quant_predict(mode, x, grad)};
   endtask

   // stop sending and let the pipeline empty
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (fqste_pkg::NUM_STAGES + 3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         fqste_pkg::CSR_SCALE:      cfg_scale = data;
         fqste_pkg::CSR_RECIP:      cfg_recip = data;
         fqste_pkg::CSR_ZERO:       cfg_zero  = data[8:0];
         fqste_pkg::CSR_RANGE_LOW:  cfg_qmin  = data[8:0];
         fqste_pkg::CSR_RANGE_HIGH: cfg_qmax  = data[8:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [31:0] scale, input logic [31:0] recip,
                                input int zp, input int qmin, input int qmax);
      drain_pipeline();
      write_reg(fqste_pkg::CSR_SCALE, scale);
      write_reg(fqste_pkg::CSR_RECIP, recip);
      // upper bits above the 9-bit fields are don't-care
      write_reg(fqste_pkg::CSR_ZERO, {$urandom_range(0, 1) ? 23'h7FFFFF : 23'd0, 9'(zp)});
      write_reg(fqste_pkg::CSR_RANGE_LOW, {23'd0, 9'(qmin)});
      write_reg(fqste_pkg::CSR_RANGE_HIGH, {23'd0, 9'(qmax)});
   endtask

   // x mostly near quantization levels and half-steps, plus raw bits and specials
   function automatic logic [31:0] pick_x();
      int          k, lo_lvl, hi_lvl;
      logic [31:0] v;
      lo_lvl = (cfg_qmin < cfg_qmax ? int'(cfg_qmin) : int'(cfg_qmax)) - int'(cfg_zero) - 3;
      hi_lvl = (cfg_qmin < cfg_qmax ? int'(cfg_qmax) : int'(cfg_qmin)) - int'(cfg_zero) + 3;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            k = $urandom_range(0, hi_lvl - lo_lvl) + lo_lvl;
            v = f_mul(f_from_int(k), cfg_scale);
            return f_nan(v) ? $urandom : v ^ 32'($urandom_range(0, 3));
         end
         3, 4, 5: begin
            k = $urandom_range(0, hi_lvl - lo_lvl) + lo_lvl;
            v = f_mul(f_add(f_from_int(k), F32_HALF), cfg_scale);
            return f_nan(v) ? $urandom : v ^ 32'($urandom_range(0, 3));
         end
         6: return $urandom;
         7: case ($urandom_range(0, 5))
               0: return F32_POS_INF;
               1: return F32_NEG_INF;
               2: return {1'b0, 8'hFF, 23'($urandom_range(1, 8388607))};
               3: return {$urandom_range(0, 1) == 1, 31'd0};
               4: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
               default: return {$urandom_range(0, 1) == 1, 8'hFE, 23'($urandom)};
            endcase
         default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 160)),
                          23'($urandom)};
      endcase
   endfunction

   task automatic random_burst(input int count);
      for (int i = 0; i < count; i++)
         send_request($urandom_range(0, 1), pick_x(), $urandom);
   endtask

   // ---------------- tests ----------------
   // reset values: scale 1, recip 1, zp 0, range -128..127
   task automatic test_reset_defaults();
      logic [31:0] fwd_x[17];
      logic [31:0] bwd_x[7];
      fwd_x = '{32'h0000_0000, 32'h8000_0000, 32'h3FC0_0000, 32'h4020_0000, 32'hC020_0000,
                32'h3EFF_FFFF, 32'h3F00_0000, 32'hBF00_0000, 32'hBECC_CCCD, 32'h42FF_3333,
                32'hC348_0000, F32_POS_INF, F32_NEG_INF, 32'h7FC0_0001, 32'h4B80_0001,
                32'h0000_0001, 32'h7F7F_FFFF};
      bwd_x = '{32'hC300_0000, 32'h42FE_0000, 32'h42FE_0001, 32'hC300_0001, 32'hFFC0_0000,
                F32_POS_INF, 32'h8000_0000};
      foreach (fwd_x[i]) send_request(MODE_FWD, fwd_x[i], $urandom);
      foreach (bwd_x[i]) send_request(MODE_BWD, bwd_x[i], $urandom | 32'h1);
   endtask

   // extreme register values, each followed by a short random burst
   task automatic test_register_extremes();
      load_settings(F32_TENTH, F32_TEN, -256, -128, 255);
      random_burst(60);
      load_settings(F32_FIVE_PC, F32_TWENTY, 255, -128, 127);
      random_burst(60);
      // crossed range: everything collapses to qmax, gradients all masked
      load_settings(fqste_pkg::ONE_F32, fqste_pkg::ONE_F32, 0, 255, -128);
      random_burst(60);
      // recip unrelated to scale
      load_settings(32'h4000_0000, 32'h4040_0000, 3, -5, 9);
      random_burst(60);
      load_settings(32'h0000_0000, 32'hFFFF_FFFF, 0, -128, 127);
      random_burst(40);
      load_settings(F32_POS_INF, 32'h0000_0000, 1, 0, 255);
      random_burst(40);
      load_settings(32'h0000_0001, 32'h7F7F_FFFF, -1, -128, 127);
      random_burst(40);
      // spare indexes must not disturb anything
      drain_pipeline();
      write_reg(CSR_SPARE_5, $urandom);
      write_reg(CSR_SPARE_7, $urandom);
      random_burst(40);
   endtask

   task automatic test_random_settings();
      int          k, zp, lo, hi;
      logic [31:0] sc, rc;
      for (int phase = 0; phase < 10; phase++) begin
         k  = $urandom_range(0, 20) - 10;
         sc = {1'b0, 8'(127 + k), 23'd0};
         rc = {1'b0, 8'(127 - k), 23'd0};
         case ($urandom_range(0, 3))
            0: begin sc = F32_TENTH; rc = F32_TEN; end
            1: rc = {1'b0, 8'($urandom_range(110, 140)), 23'($urandom)};
            default: ;
         endcase
         zp = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 511)) - 256;
         case ($urandom_range(0, 3))
            0: begin lo = -128; hi = 127; end
            1: begin lo = 0; hi = 255; end
            2: begin lo = int'($urandom_range(0, 383)) - 128; hi = int'($urandom_range(0, 383)) - 128; end
            default: begin lo = int'($urandom_range(0, 20)) - 10; hi = lo + int'($urandom_range(0, 15)); end
         endcase
         load_settings(sc, rc, zp, lo, hi);
         quiet_phase = (phase == 4);
         random_burst(70);
         // hold off once mid-phase until everything has come back
         if (phase == 6) drain_pipeline();
         random_burst(60);
      end
      quiet_phase = 1'b0;
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_mode         <= MODE_FWD;
      req_x_value      <= 32'd0;
      req_grad_value   <= 32'd0;
      csr_write_enable <= 1'b0;
      csr_index        <= fqste_pkg::CSR_SCALE;
      csr_data         <= 32'd0;
      quiet_phase      = 1'b0;
      mismatch_count   = 0;
      cfg_scale        = fqste_pkg::ONE_F32;
      cfg_recip        = fqste_pkg::ONE_F32;
      cfg_zero         = 9'sd0;
      cfg_qmin         = fqste_pkg::RANGE_LOW_RST;
      cfg_qmax         = fqste_pkg::RANGE_HIGH_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_random_settings();
      drain_pipeline();

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/fqste_pkg.sv
src/fake_quantize_ste.sv
tb/sv/testbench.sv
